FILE: sv/tmtw_pkg.sv
package tmtw_pkg;

  // Defaults for the top-level parameters.
  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int MAX_DIGITS_DEF = 64;

  // Fixed field widths.
  localparam int CHAR_W       = 8;
  localparam int ATTR_W       = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int CELL_DATA_W  = ATTR_W + CHAR_W;
  localparam int VALUE_W      = 64;
  localparam int RADIX_W      = 6;
  localparam int DIGIT_W      = 6;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IDX_ATTRIBUTE = 1'b0;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  // Radix limits.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_BITS_PER_CYCLE = 8;

  // Cursor step of a tab.
  localparam int TAB_STEP = 4;

  // Control bytes.
  localparam logic [CHAR_W-1:0] CHAR_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_DIV,
    S_READ,
    S_EMIT,
    S_OUT
  } tmtw_state_e;

  // Divider commands from the sequencer.
  typedef struct packed {
    logic load;   // start on a new dividend and divisor
    logic next;   // start the next digit on the current quotient
  } tmtw_div_ctl_t;

  // What the cursor unit reports for the byte at its input.
  typedef struct packed {
    logic                    wr;
    logic [CELL_INDEX_W-1:0] index;
  } tmtw_cell_t;

  function automatic logic [CHAR_W-1:0] digit_to_byte(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] b;
    if (d < DIGIT_TEN) begin
      b = CHAR_ZERO + CHAR_W'(d);
    end else begin
      b = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return b;
  endfunction

endpackage

FILE: sv/tmtw_ram.sv
module tmtw_ram
  import tmtw_pkg::*;
#(
  parameter int WIDTH = DIGIT_W,
  parameter int DEPTH = MAX_DIGITS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tmtw_divider.sv
module tmtw_divider
  import tmtw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmtw_div_ctl_t       ctl_i,
  input  logic [VALUE_W-1:0]  dividend_i,
  input  logic [RADIX_W-1:0]  divisor_i,
  output logic                busy_o,
  output logic [VALUE_W-1:0]  quotient_o,
  output logic [DIGIT_W-1:0]  remainder_o
);

  localparam int STEPS = VALUE_W / DIV_BITS_PER_CYCLE;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic               run_q;
  logic [SW-1:0]      cnt_q;
  logic [VALUE_W-1:0] work_q, work_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] div_q;

  // Restoring division, several bits per cycle. The partial remainder stays
  // below the divisor, so it fits in six bits; quotient bits shift in at the
  // bottom of the working register as dividend bits leave at the top.
  always_comb begin
    logic [DIGIT_W:0] r7;
    work_d = work_q;
    rem_d  = rem_q;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      r7     = {rem_d, work_d[VALUE_W-1]};
      work_d = {work_d[VALUE_W-2:0], 1'b0};
      if (r7 >= {1'b0, div_q}) begin
        r7        = r7 - {1'b0, div_q};
        work_d[0] = 1'b1;
      end
      rem_d = r7[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (ctl_i.load || ctl_i.next) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + SW'(1);
      if (cnt_q == SW'(STEPS - 1)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      work_q <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
    end else if (ctl_i.next) begin
      rem_q <= '0;
    end else if (run_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o      = run_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

FILE: sv/tmtw_cursor.sv
module tmtw_cursor
  import tmtw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [CHAR_W-1:0] byte_i,
  output tmtw_cell_t        cell_o
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_n;
  logic          row_adv;
  logic          wr;
  logic [31:0]   idx_full;

  always_comb begin
    wr      = 1'b0;
    row_adv = 1'b0;
    col_n   = {1'b0, col_q};
    unique case (byte_i)
      CHAR_CR: begin
        col_n = '0;
      end
      CHAR_LF: begin
        col_n   = '0;
        row_adv = 1'b1;
      end
      CHAR_TAB: begin
        col_n = {1'b0, col_q} + (CW+1)'(TAB_STEP);
      end
      CHAR_VT: begin
        row_adv = 1'b1;
      end
      CHAR_BEL: begin
      end
      default: begin
        wr    = 1'b1;
        col_n = {1'b0, col_q} + (CW+1)'(1);
      end
    endcase
    // Running off the right edge starts the next line.
    if (col_n >= (CW+1)'(COLUMNS)) begin
      col_n   = '0;
      row_adv = 1'b1;
    end
    col_d = col_n[CW-1:0];
    row_d = row_q;
    if (row_adv) begin
      row_d = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);
    end
  end

  assign idx_full     = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);
  assign cell_o.wr    = wr;
  assign cell_o.index = idx_full[CELL_INDEX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/text_mode_terminal_writer_top.sv
// Text-mode console cell writer. Each request either carries one character
// byte (mode 0) or an unsigned 64-bit number to print in radix 2 to 36
// (mode 1). Non-control bytes and digits become cell writes on the output
// channel: the cell index is row * COLUMNS + column, and the cell data holds
// the attribute register in the upper byte and the character in the lower
// byte; the last cell write of a request carries last_write. Carriage return,
// line feed, tab, vertical tab and bell at most move the cursor and produce no
// cell write. The block handles one request at a time and drops in_ready_o
// until all of its cell writes have been taken. A number request runs the
// divider, which resolves eight quotient bits per cycle of a 64-bit value,
// once per digit and pushes each remainder onto the digit stack memory;
// then the digits are read back, formatted and handed over. The attribute
// register sits at address 0 of the APB port and resets to 7; write it only
// while the block is idle.
module text_mode_terminal_writer_top
  import tmtw_pkg::*;
#(
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  // Request channel.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [CHAR_W-1:0]       char_code_i,
  input  logic [VALUE_W-1:0]      number_value_i,
  input  logic [RADIX_W-1:0]      number_radix_i,
  // Cell write channel.
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CELL_INDEX_W-1:0] cell_index_o,
  output logic [CELL_DATA_W-1:0]  cell_data_o,
  output logic                    last_write_o
);

  localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  tmtw_state_e state_q, state_d;

  logic [ATTR_W-1:0] attribute_q;
  logic [CHAR_W-1:0] char_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_dec;

  logic                    out_valid_q;
  logic [CELL_INDEX_W-1:0] cell_index_q;
  logic [CELL_DATA_W-1:0]  cell_data_q;
  logic                    last_q;

  // Sequencer outputs.
  tmtw_div_ctl_t     div_ctl;
  logic              ram_we;
  logic              ram_re;
  logic              cur_step;
  logic [CHAR_W-1:0] cur_byte;
  logic              out_load;
  logic              out_last;

  logic               div_busy;
  logic [VALUE_W-1:0] quotient;
  logic [DIGIT_W-1:0] remainder;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [RADIX_W-1:0] radix_clamped;
  logic               more_digits;
  logic               cfg_write;
  tmtw_cell_t         cur_cell;

  // ---------------------------------------------------------------------
  // Configuration register. Only the word index is decoded; the low
  // address bits select bytes within the word and are ignored.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attribute_q <= ATTR_RESET;
    end else if (cfg_write && (paddr[PADDR_W-1] == REG_IDX_ATTRIBUTE)) begin
      attribute_q <= pwdata[ATTR_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_IDX_ATTRIBUTE) ?
                  PDATA_W'(attribute_q) : '0;

  // ---------------------------------------------------------------------
  // Divider, digit stack and the cursor unit that both modes share.
  // ---------------------------------------------------------------------
  always_comb begin
    radix_clamped = number_radix_i;
    if (number_radix_i < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (number_radix_i > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end
  end

  tmtw_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (number_value_i),
    .divisor_i   (radix_clamped),
    .busy_o      (div_busy),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  assign count_dec = count_q - CNT_W'(1);

  tmtw_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (remainder),
    .re_i    (ram_re),
    .raddr_i (count_dec[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  tmtw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (cur_step),
    .byte_i (cur_byte),
    .cell_o (cur_cell)
  );

  // Another digit follows while the quotient is nonzero and the stack still
  // has room after the digit being pushed now.
  assign more_digits = (quotient != '0) && (count_q != CNT_W'(MAX_DIGITS - 1));

  // ---------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = mode_i ? S_DIV : S_CHAR;
        end
      end
      S_CHAR: begin
        state_d = cur_cell.wr ? S_OUT : S_IDLE;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = more_digits ? S_DIV : S_READ;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = last_q ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs.
  // ---------------------------------------------------------------------
  always_comb begin
    div_ctl  = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    cur_step = 1'b0;
    cur_byte = char_q;
    out_load = 1'b0;
    out_last = 1'b0;
    count_d  = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && mode_i) begin
          div_ctl.load = 1'b1;
          count_d      = '0;
        end
      end
      S_CHAR: begin
        // A control byte at most moves the cursor.
        cur_step = 1'b1;
        out_load = cur_cell.wr;
        out_last = 1'b1;
      end
      S_DIV: begin
        if (!div_busy) begin
          ram_we       = 1'b1;
          count_d      = count_q + CNT_W'(1);
          div_ctl.next = more_digits;
        end
      end
      S_READ: begin
        // Digits come off the stack most significant first.
        ram_re  = 1'b1;
        count_d = count_dec;
      end
      S_EMIT: begin
        cur_step = 1'b1;
        cur_byte = digit_to_byte(ram_rdata);
        out_load = 1'b1;
        out_last = (count_q == '0);
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        last_q      <= out_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      char_q <= char_code_i;
    end
    if (out_load) begin
      cell_index_q <= cur_cell.index;
      cell_data_q  <= {attribute_q, cur_byte};
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cell_index_o = cell_index_q;
  assign cell_data_o  = cell_data_q;
  assign last_write_o = last_q;

endmodule

FILE: sv/tmtw_checker.sv
module tmtw_checker
  import tmtw_pkg::*;
#(
  parameter int COLUMNS    = COLUMNS_DEF,
  parameter int ROWS       = ROWS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [CELL_INDEX_W-1:0] cell_index_o,
  input logic [CELL_DATA_W-1:0]  cell_data_o,
  input logic                    last_write_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;

  // A pending cell write holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_index_o)
      && $stable(cell_data_o) && $stable(last_write_o))
    else $error("cell write changed while stalled");

  // The block takes no request while a cell write is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a cell write is pending");

  // An accepted request keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready right after accepting a request");

  // Only number printing gives more than one write, and those are digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_write_o |->
      (cell_data_o[CHAR_W-1:0] >= CHAR_ZERO && cell_data_o[CHAR_W-1:0] <= CHAR_NINE) ||
      (cell_data_o[CHAR_W-1:0] >= CHAR_UPPER_A && cell_data_o[CHAR_W-1:0] <= CHAR_UPPER_Z))
    else $error("non-final cell write is not a digit");

  // The cell index stays on the screen when the screen fits the index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CELLS <= (1 << CELL_INDEX_W)) |->
      32'(cell_index_o) < 32'(CELLS))
    else $error("cell index beyond the screen");

endmodule

bind text_mode_terminal_writer_top tmtw_checker #(
  .COLUMNS    (COLUMNS),
  .ROWS       (ROWS),
  .MAX_DIGITS (MAX_DIGITS)
) u_tmtw_checker (.*);

FILE: verif/text_mode_terminal_writer_top_tb.sv
module text_mode_terminal_writer_top_tb
  import tmtw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the screen, taken from the defaults the block is built with.
  localparam int COLUMNS    = COLUMNS_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int MAX_DIGITS = MAX_DIGITS_DEF;

  // The attribute register is the first register of the APB port.
  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_IDX_ATTRIBUTE));

  // Random part: several phases, each under its own attribute value.
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 27;

  // A request that only moves the cursor gives no cell write, so once the
  // last expected cell write is in, the block may still be busy with such a
  // request. This margin covers that before an attribute write.
  localparam int SETTLE_CYCLES = 12;

  // The slowest run is about 160 requests of 64 binary digits each, with
  // every cell write held off by a long stall. The limit is several times it.
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [CHAR_W-1:0] CONTROL_BYTES [5] = '{CHAR_CR, CHAR_LF, CHAR_TAB,
                                                       CHAR_VT, CHAR_BEL};

  typedef struct {
    logic                    mode;
    logic [CHAR_W-1:0]       char_code;
    logic [VALUE_W-1:0]      value;
    logic [RADIX_W-1:0]      radix;
  } request_t;

  typedef struct {
    logic [CELL_INDEX_W-1:0] index;
    logic [CELL_DATA_W-1:0]  data;
    logic                    last;
  } cell_t;

  // One row of the directed table. Where typed is set, the single cell
  // write of the request is given here instead of being predicted.
  typedef struct {
    request_t req;
    bit       typed;
    cell_t    known_cell;
  } stim_row_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [PADDR_W-1:0]      paddr          = '0;
  logic [PDATA_W-1:0]      pwdata         = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic                    mode_i         = 1'b0;
  logic [CHAR_W-1:0]       char_code_i    = '0;
  logic [VALUE_W-1:0]      number_value_i = '0;
  logic [RADIX_W-1:0]      number_radix_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [CELL_INDEX_W-1:0] cell_index_o;
  logic [CELL_DATA_W-1:0]  cell_data_o;
  logic                    last_write_o;

  text_mode_terminal_writer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .char_code_i    (char_code_i),
    .number_value_i (number_value_i),
    .number_radix_i (number_radix_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_index_o   (cell_index_o),
    .cell_data_o    (cell_data_o),
    .last_write_o   (last_write_o)
  );

  // 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Screen model. It keeps its own cursor and attribute and turns every
  // accepted request into the cell writes the block has to produce.
  // ---------------------------------------------------------------------
  logic [ATTR_W-1:0] attr_now = ATTR_RESET;
  int unsigned       cur_row  = 0;
  int unsigned       cur_col  = 0;
  cell_t             fresh_cells[$];   // cell writes of the request just accepted
  cell_t             cells_due[$];     // cell writes still to come from the block

  int unsigned row_wraps      = 0;
  int unsigned col_overflows  = 0;
  int unsigned number_reqs    = 0;
  int unsigned char_reqs      = 0;
  int unsigned cells_checked  = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;  // when set, neither side idles

  function automatic void next_line();
    if (cur_row + 1 >= ROWS) begin
      cur_row = 0;
      row_wraps++;
    end else begin
      cur_row++;
    end
  endfunction

  // Handles one byte exactly as the block does: control bytes at most move the
  // cursor, any other byte (NUL included) writes a cell and steps right.
  function automatic void place_byte(input logic [CHAR_W-1:0] b);
    cell_t c;
    case (b)
      CHAR_CR: begin
        cur_col = 0;
      end
      CHAR_LF: begin
        cur_col = 0;
        next_line();
      end
      CHAR_TAB: begin
        cur_col += TAB_STEP;
      end
      CHAR_VT: begin
        next_line();
      end
      CHAR_BEL: begin
      end
      default: begin
        c.index = CELL_INDEX_W'(cur_row * COLUMNS + cur_col);
        c.data  = {attr_now, b};
        c.last  = 1'b0;
        fresh_cells.push_back(c);
        cur_col++;
      end
    endcase
    // Running off the right edge, by a cell or by a tab, starts a new line.
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      col_overflows++;
      next_line();
    end
  endfunction

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    return (d < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(d) : CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
  endfunction

  function automatic void expand_request(input request_t r);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int                 n;
    fresh_cells.delete();
    if (!r.mode) begin
      place_byte(r.char_code);
    end else begin
      // A radix outside 2..36 is pulled to the nearest end of the range.
      base = VALUE_W'(r.radix);
      if (base < VALUE_W'(RADIX_MIN)) base = VALUE_W'(RADIX_MIN);
      if (base > VALUE_W'(RADIX_MAX)) base = VALUE_W'(RADIX_MAX);
      v = r.value;
      n = 0;
      do begin
        digits[n] = DIGIT_W'(v % base);
        v = v / base;
        n++;
      end while (v != 0 && n < MAX_DIGITS);
      for (int i = n - 1; i >= 0; i--) place_byte(digit_glyph(digits[i]));
    end
    if (fresh_cells.size() > 0) fresh_cells[fresh_cells.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Idling. Most gaps are zero or short, a few are long. While steady is
  // set both sides run without gaps.
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The cell write side is ready for a random run of cycles, then may stall.
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking. Every cell write taken from the block is compared field by
  // field with the oldest one still due.
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input cell_t want, input cell_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected index %0d data %04h last %0b, got index %0d data %04h last %0b",
               $realtime, what, want.index, want.data, want.last,
               got.index, got.data, got.last);
    end
  endtask

  always @(posedge clk_i) begin
    cell_t got;
    cell_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.index = cell_index_o;
      got.data  = cell_data_o;
      got.last  = last_write_o;
      cells_checked++;
      if (cells_due.size() == 0) begin
        want = '{index: '0, data: '0, last: 1'b0};
        flag_mismatch("cell write with none due", want, got);
      end else begin
        want = cells_due.pop_front();
        if (got.index !== want.index || got.data !== want.data || got.last !== want.last) begin
          flag_mismatch("cell write mismatch", want, got);
        end
      end
    end
  end

  // A cycle counter bounds the run in case the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped at the cycle limit with %0d cell writes still due.",
             cells_due.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus. Every task starts and ends just after a rising edge, and all
  // inputs change by nonblocking assignment at that edge.
  // ---------------------------------------------------------------------

  // Offers one request after a random gap and waits for it to be taken.
  // Valid is only lowered when a gap follows, so a back-to-back request
  // keeps valid high and just swaps the payload.
  task automatic drive_request(input request_t r, input bit typed, input cell_t typed_cell);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= r.mode;
    char_code_i    <= r.char_code;
    number_value_i <= r.value;
    number_radix_i <= r.radix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted at this edge: the model moves on and its cell writes fall due.
    expand_request(r);
    if (r.mode) number_reqs++;
    else char_reqs++;
    if (typed) cells_due.push_back(typed_cell);
    else foreach (fresh_cells[i]) cells_due.push_back(fresh_cells[i]);
  endtask

  // Holds off new requests until every cell write due has come, then gives
  // the block time to finish a request that moved the cursor only.
  task automatic drain_writer();
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    attr_now = value;
  endtask

  function automatic request_t random_request();
    request_t    r;
    int unsigned roll;
    r.mode      = ($urandom_range(0, 9) < 4);
    r.char_code = CHAR_W'($urandom_range(0, 255));
    r.value     = {$urandom, $urandom};
    r.radix     = RADIX_W'($urandom_range(0, 63));
    if (!r.mode) begin
      // Control bytes are frequent enough to wrap the rows several times.
      if ($urandom_range(0, 9) < 3) r.char_code = CONTROL_BYTES[$urandom_range(0, 4)];
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 2) r.value = VALUE_W'($urandom_range(0, 40));
      else if (roll < 8) r.value = r.value >> $urandom_range(0, 63);
      // Most radixes are legal; the rest span 0..63 and can hit the clamping at both ends.
      if ($urandom_range(0, 9) < 9) r.radix = RADIX_W'($urandom_range(2, 36));
    end
    return r;
  endfunction

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic mode, input logic [CHAR_W-1:0] ch,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [RADIX_W-1:0] radix, input bit typed = 1'b0,
                                  input int unsigned index = 0, input int unsigned data = 0);
    stim_row_t row;
    row.req              = '{mode: mode, char_code: ch, value: value, radix: radix};
    row.typed            = typed;
    row.known_cell.index = CELL_INDEX_W'(index);
    row.known_cell.data  = CELL_DATA_W'(data);
    row.known_cell.last  = 1'b1;
    directed_rows.push_back(row);
  endfunction

  initial begin
    logic [ATTR_W-1:0] phase_attr;
    logic [VALUE_W-1:0] all_ones;
    cell_t             none;

    all_ones = '1;
    none     = '{index: '0, data: '0, last: 1'b0};

    // Directed table. The first three rows follow reset, where the cursor
    // is at the top left and the attribute is 7, so their cells are known.
    add_row(1'b0, 8'h41, '0, '0, 1'b1, 0, 16'h0741);
    add_row(1'b0, 8'h00, '0, '0, 1'b1, 1, 16'h0700);
    add_row(1'b0, 8'hFF, '0, '0, 1'b1, 2, 16'h07FF);
    // Each control byte, and a printable byte with the number fields at
    // their top, which the block has to ignore.
    add_row(1'b0, CHAR_CR,  '0, '0);
    add_row(1'b0, CHAR_LF,  '0, '0);
    add_row(1'b0, CHAR_TAB, '0, '0);
    add_row(1'b0, CHAR_VT,  '0, '0);
    add_row(1'b0, CHAR_BEL, '0, '0);
    add_row(1'b0, 8'h20, all_ones, '1);
    // Numbers: zero, the largest value in the common radixes, and radixes
    // outside 2..36 at both ends.
    add_row(1'b1, 8'h00, '0, 6'd10);
    add_row(1'b1, 8'h00, all_ones, 6'd2);
    add_row(1'b1, 8'h00, all_ones, 6'd16);
    add_row(1'b1, 8'h00, all_ones, 6'd36);
    add_row(1'b1, 8'h00, all_ones, 6'd10);
    add_row(1'b1, 8'h00, 64'd5, 6'd0);
    add_row(1'b1, 8'h00, 64'd35, 6'd63);
    add_row(1'b1, 8'h00, 64'd7, 6'd1);
    add_row(1'b1, 8'h00, 64'd36, 6'd37);
    add_row(1'b1, 8'hFF, 64'd1234567890, 6'd10);
    // From the start of a line, 64 plus 13 digits leave the cursor at
    // column 77, so the tab that follows runs off the right edge.
    add_row(1'b0, CHAR_LF, '0, '0);
    add_row(1'b1, 8'h00, all_ones, 6'd2);
    add_row(1'b1, 8'h00, 64'd1234567890123, 6'd10);
    add_row(1'b0, CHAR_TAB, '0, '0);

    // Reset is asserted once, at the start.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_request(directed_rows[i].req, directed_rows[i].typed,
                    directed_rows[i].known_cell);
    end

    // Random phases. Before each one the sender waits for every cell write
    // to come back, then the attribute changes: both extremes first, then
    // random values. The second phase runs without any idling.
    for (int p = 0; p < PHASES; p++) begin
      drain_writer();
      case (p)
        0:       phase_attr = 8'hFF;
        1:       phase_attr = 8'h00;
        default: phase_attr = ATTR_W'($urandom_range(0, 255));
      endcase
      write_attribute(phase_attr);
      steady = (p == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) drive_request(random_request(), 1'b0, none);
    end

    drain_writer();
    repeat (20) @(posedge clk_i);

    $display("Checked %0d cell writes from %0d character and %0d number requests",
             cells_checked, char_reqs, number_reqs);
    $display("under %0d attribute values, with %0d line overflows and %0d screen wraps.",
             PHASES + 1, col_overflows, row_wraps);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d cell write mismatches.", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: text_mode_terminal_writer_top.f
sv/tmtw_pkg.sv
sv/tmtw_ram.sv
sv/tmtw_divider.sv
sv/tmtw_cursor.sv
sv/text_mode_terminal_writer_top.sv
sv/tmtw_checker.sv
verif/text_mode_terminal_writer_top_tb.sv
